// ===== hw/rtl/qcsl_pkg.sv =====
package qcsl_pkg;

  localparam int CORNER_W  = 24;
  localparam int DIFF_W    = CORNER_W + 1;
  localparam int MAG_W     = CORNER_W;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int SPLIT_W   = 26;
  localparam int NUM_W     = CROSS_W + MAG_W;
  localparam int QUO_W     = 25;
  localparam int SIDE_W    = 25;
  localparam int SUMSQ_W   = 2 * MAG_W + 1;
  localparam int ROOT_W    = SUMSQ_W + 1;
  localparam int HEAD_STAGES = 6;
  localparam int NUM_STAGES  = HEAD_STAGES + QUO_W + 1;

  localparam logic signed [CORNER_W-1:0] COORD_MIN = {1'b1, {(CORNER_W-1){1'b0}}};
  localparam logic signed [CORNER_W-1:0] COORD_MAX = {1'b0, {(CORNER_W-1){1'b1}}};

  typedef struct packed {
    logic signed [CORNER_W-1:0] corner0_x;
    logic signed [CORNER_W-1:0] corner0_y;
    logic signed [CORNER_W-1:0] corner1_x;
    logic signed [CORNER_W-1:0] corner1_y;
    logic signed [CORNER_W-1:0] corner2_x;
    logic signed [CORNER_W-1:0] corner2_y;
    logic signed [CORNER_W-1:0] corner3_x;
    logic signed [CORNER_W-1:0] corner3_y;
  } corners_t;

  typedef struct packed {
    logic signed [CORNER_W-1:0] center_x;
    logic signed [CORNER_W-1:0] center_y;
    logic [SIDE_W-1:0]          side_0;
    logic [SIDE_W-1:0]          side_1;
    logic [SIDE_W-1:0]          side_2;
    logic [SIDE_W-1:0]          side_3;
    logic [SIDE_W-1:0]          largest_side;
    logic [SIDE_W-1:0]          smallest_side;
    logic                       degenerate;
    logic                       center_clipped;
  } result_t;

  typedef struct packed {
    logic [NUM_W-1:0]           remx;
    logic [NUM_W-1:0]           remy;
    logic [QUO_W-1:0]           qx;
    logic [QUO_W-1:0]           qy;
    logic [CROSS_W-1:0]         dm;
    logic                       negx;
    logic                       negy;
    logic                       bigx;
    logic                       bigy;
    logic                       degen;
    logic signed [CORNER_W-1:0] bx;
    logic signed [CORNER_W-1:0] by;
    logic [3:0][ROOT_W-1:0]     rv;
    logic [3:0][ROOT_W-1:0]     rr;
  } iter_t;

  typedef struct packed {
    logic signed [CORNER_W-1:0] val;
    logic                       clip;
  } center_t;

  function automatic logic signed [DIFF_W-1:0] sub_ext(
    input logic signed [CORNER_W-1:0] a,
    input logic signed [CORNER_W-1:0] b
  );
    return {a[CORNER_W-1], a} - {b[CORNER_W-1], b};
  endfunction

  function automatic logic [MAG_W-1:0] abs_diff(
    input logic signed [CORNER_W-1:0] a,
    input logic signed [CORNER_W-1:0] b
  );
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0] m;
    d = sub_ext(a, b);
    m = d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
    return m[MAG_W-1:0];
  endfunction

  function automatic center_t fix_center(
    input logic signed [CORNER_W-1:0] base,
    input logic [QUO_W-1:0]           q,
    input logic                       neg,
    input logic                       big
  );
    center_t r;
    logic signed [CORNER_W+2:0] be;
    logic signed [CORNER_W+2:0] qe;
    logic signed [CORNER_W+2:0] s;
    be = {{3{base[CORNER_W-1]}}, base};
    qe = {{(CORNER_W+3-QUO_W){1'b0}}, q};
    s  = neg ? (be - qe) : (be + qe);
    r.clip = 1'b1;
    if (big) begin
      r.val = neg ? COORD_MIN : COORD_MAX;
    end else if (s < $signed({{3{COORD_MIN[CORNER_W-1]}}, COORD_MIN})) begin
      r.val = COORD_MIN;
    end else if (s > $signed({{3{COORD_MAX[CORNER_W-1]}}, COORD_MAX})) begin
      r.val = COORD_MAX;
    end else begin
      r.val  = s[CORNER_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/qcsl_stream_if.sv =====
interface qcsl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/quad_center_and_side_lengths_unit.sv =====
// Quadrilateral center and side lengths.
// The corners channel carries one transaction per quadrilateral: four corners
// in signed Q16.8. The result channel carries one transaction per input: the
// diagonal intersection, the four side lengths, the largest and smallest side
// and the degenerate and clipped flags.
// A result passes the difference, product, cross product, magnitude, numerator
// and overflow check stages, the divide and root steps and the final stage.
// Throughput is one transaction per cycle while the skid register is empty.
// The depth comes from the divider that forms the center, one quotient bit per
// stage over 25 stages, beside four square root units of 25 stages each.
// All pipeline stages advance together. When the receiver stalls, one result
// moves into a skid register, so the stage before it is freed, and ready on
// the corners channel drops until the skid register has been emptied.
// Reset is synchronous and clears every valid bit, that of the skid register
// too; the pipeline can accept a transaction as soon as reset is released.
module quad_center_and_side_lengths_unit (
  input logic        clk,
  input logic        rst,
  qcsl_stream_if.sink   corners,
  qcsl_stream_if.source result
);

  localparam int NS  = qcsl_pkg::NUM_STAGES;
  localparam int DW  = qcsl_pkg::DIFF_W;
  localparam int MW  = qcsl_pkg::MAG_W;
  localparam int PW  = qcsl_pkg::PROD_W;
  localparam int CW  = qcsl_pkg::CROSS_W;
  localparam int SPW = qcsl_pkg::SPLIT_W;
  localparam int NW  = qcsl_pkg::NUM_W;
  localparam int QW  = qcsl_pkg::QUO_W;
  localparam int SQW = qcsl_pkg::SUMSQ_W;
  localparam int RW  = qcsl_pkg::ROOT_W;
  localparam int KW  = qcsl_pkg::CORNER_W;
  localparam int SW  = qcsl_pkg::SIDE_W;

  logic [NS-1:0] vld;
  logic          en;
  logic          skid_v;
  qcsl_pkg::result_t skid;
  qcsl_pkg::result_t fin;

  assign en            = !skid_v;
  assign corners.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], corners.valid};
    end
  end

  // Stage 1: differences.
  logic signed [KW-1:0] cx [4];
  logic signed [KW-1:0] cy [4];
  always_comb begin
    cx[0] = corners.data.corner0_x;
    cy[0] = corners.data.corner0_y;
    cx[1] = corners.data.corner1_x;
    cy[1] = corners.data.corner1_y;
    cx[2] = corners.data.corner2_x;
    cy[2] = corners.data.corner2_y;
    cx[3] = corners.data.corner3_x;
    cy[3] = corners.data.corner3_y;
  end

  logic signed [DW-1:0] s1_dax, s1_day, s1_dbx, s1_dby, s1_e1x, s1_e1y;
  logic [MW-1:0]        s1_sdx [4];
  logic [MW-1:0]        s1_sdy [4];
  logic signed [KW-1:0] s1_bx, s1_by;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dax <= qcsl_pkg::sub_ext(cx[2], cx[0]);
      s1_day <= qcsl_pkg::sub_ext(cy[2], cy[0]);
      s1_dbx <= qcsl_pkg::sub_ext(cx[3], cx[1]);
      s1_dby <= qcsl_pkg::sub_ext(cy[3], cy[1]);
      s1_e1x <= qcsl_pkg::sub_ext(cx[1], cx[0]);
      s1_e1y <= qcsl_pkg::sub_ext(cy[1], cy[0]);
      for (int k = 0; k < 4; k++) begin
        s1_sdx[k] <= qcsl_pkg::abs_diff(cx[(k + 1) % 4], cx[k]);
        s1_sdy[k] <= qcsl_pkg::abs_diff(cy[(k + 1) % 4], cy[k]);
      end
      s1_bx <= cx[0];
      s1_by <= cy[0];
    end
  end

  // Stage 2: products and squares.
  logic signed [PW-1:0] p0_c, p1_c, p2_c, p3_c;
  assign p0_c = s1_dax * s1_dby;
  assign p1_c = s1_day * s1_dbx;
  assign p2_c = s1_e1x * s1_dby;
  assign p3_c = s1_e1y * s1_dbx;

  logic signed [PW-1:0] s2_p0, s2_p1, s2_p2, s2_p3;
  logic [2*MW-1:0]      s2_sqx [4];
  logic [2*MW-1:0]      s2_sqy [4];
  logic signed [DW-1:0] s2_dax, s2_day;
  logic signed [KW-1:0] s2_bx, s2_by;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p0 <= p0_c;
      s2_p1 <= p1_c;
      s2_p2 <= p2_c;
      s2_p3 <= p3_c;
      for (int k = 0; k < 4; k++) begin
        s2_sqx[k] <= s1_sdx[k] * s1_sdx[k];
        s2_sqy[k] <= s1_sdy[k] * s1_sdy[k];
      end
      s2_dax <= s1_dax;
      s2_day <= s1_day;
      s2_bx  <= s1_bx;
      s2_by  <= s1_by;
    end
  end

  // Stage 3: cross products and sums of squares.
  logic signed [CW-1:0] s3_denom, s3_tnum;
  logic [SQW-1:0]       s3_sum [4];
  logic signed [DW-1:0] s3_dax, s3_day;
  logic signed [KW-1:0] s3_bx, s3_by;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_denom <= {s2_p0[PW-1], s2_p0} - {s2_p1[PW-1], s2_p1};
      s3_tnum  <= {s2_p2[PW-1], s2_p2} - {s2_p3[PW-1], s2_p3};
      for (int k = 0; k < 4; k++) begin
        s3_sum[k] <= {1'b0, s2_sqx[k]} + {1'b0, s2_sqy[k]};
      end
      s3_dax <= s2_dax;
      s3_day <= s2_day;
      s3_bx  <= s2_bx;
      s3_by  <= s2_by;
    end
  end

  // Stage 4: magnitudes and split products of tnum and the diagonal.
  logic [CW-1:0] tm_c, dm_c;
  logic [DW-1:0] axm25_c, aym25_c;
  logic [MW-1:0] axm_c, aym_c;
  assign tm_c    = s3_tnum[CW-1] ? (~s3_tnum + CW'(1)) : s3_tnum;
  assign dm_c    = s3_denom[CW-1] ? (~s3_denom + CW'(1)) : s3_denom;
  assign axm25_c = s3_dax[DW-1] ? (~s3_dax + DW'(1)) : s3_dax;
  assign aym25_c = s3_day[DW-1] ? (~s3_day + DW'(1)) : s3_day;
  assign axm_c   = axm25_c[MW-1:0];
  assign aym_c   = aym25_c[MW-1:0];

  logic [SPW+MW-1:0]      s4_lx, s4_ly;
  logic [CW-SPW+MW-1:0]   s4_hx, s4_hy;
  logic [CW-1:0]          s4_dm;
  logic                   s4_negx, s4_negy, s4_degen;
  logic [SQW-1:0]         s4_sum [4];
  logic signed [KW-1:0]   s4_bx, s4_by;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_lx    <= tm_c[SPW-1:0] * axm_c;
      s4_hx    <= tm_c[CW-1:SPW] * axm_c;
      s4_ly    <= tm_c[SPW-1:0] * aym_c;
      s4_hy    <= tm_c[CW-1:SPW] * aym_c;
      s4_dm    <= dm_c;
      s4_negx  <= s3_tnum[CW-1] ^ s3_dax[DW-1] ^ s3_denom[CW-1];
      s4_negy  <= s3_tnum[CW-1] ^ s3_day[DW-1] ^ s3_denom[CW-1];
      s4_degen <= (s3_denom == '0);
      s4_sum   <= s3_sum;
      s4_bx    <= s3_bx;
      s4_by    <= s3_by;
    end
  end

  // Stage 5: full numerators.
  logic [NW-1:0]        s5_nx, s5_ny;
  logic [CW-1:0]        s5_dm;
  logic                 s5_negx, s5_negy, s5_degen;
  logic [SQW-1:0]       s5_sum [4];
  logic signed [KW-1:0] s5_bx, s5_by;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_nx    <= {s4_hx, {SPW{1'b0}}} + NW'(s4_lx);
      s5_ny    <= {s4_hy, {SPW{1'b0}}} + NW'(s4_ly);
      s5_dm    <= s4_dm;
      s5_negx  <= s4_negx;
      s5_negy  <= s4_negy;
      s5_degen <= s4_degen;
      s5_sum   <= s4_sum;
      s5_bx    <= s4_bx;
      s5_by    <= s4_by;
    end
  end

  // Stage 6: overflow check of the quotient, then the divide and root steps.
  qcsl_pkg::iter_t it [QW+1];
  logic [NW+QW:0]  dtop_c;
  assign dtop_c = (NW+QW+1)'({s5_dm, {QW{1'b0}}});

  always_ff @(posedge clk) begin
    if (en) begin
      it[0].remx  <= s5_nx;
      it[0].remy  <= s5_ny;
      it[0].qx    <= '0;
      it[0].qy    <= '0;
      it[0].dm    <= s5_dm;
      it[0].negx  <= s5_negx;
      it[0].negy  <= s5_negy;
      it[0].bigx  <= ((NW+QW+1)'(s5_nx) >= dtop_c);
      it[0].bigy  <= ((NW+QW+1)'(s5_ny) >= dtop_c);
      it[0].degen <= s5_degen;
      it[0].bx    <= s5_bx;
      it[0].by    <= s5_by;
      for (int k = 0; k < 4; k++) begin
        it[0].rv[k] <= RW'(s5_sum[k]);
        it[0].rr[k] <= '0;
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int SH  = QW - 1 - j;
    localparam int RSH = SQW - 1 - 2 * j;
    logic [NW:0]   dsh, ex, ey, dfx, dfy;
    logic          gex, gey;
    logic [RW-1:0] rbit;
    logic [RW-1:0] trial [4];
    logic          rge [4];
    qcsl_pkg::iter_t nxt;

    assign dsh  = (NW+1)'(it[j].dm) << SH;
    assign ex   = {1'b0, it[j].remx};
    assign ey   = {1'b0, it[j].remy};
    assign gex  = ex >= dsh;
    assign gey  = ey >= dsh;
    assign dfx  = ex - dsh;
    assign dfy  = ey - dsh;
    assign rbit = RW'(1) << RSH;

    always_comb begin
      nxt = it[j];
      nxt.remx = gex ? dfx[NW-1:0] : it[j].remx;
      nxt.remy = gey ? dfy[NW-1:0] : it[j].remy;
      nxt.qx[SH] = gex;
      nxt.qy[SH] = gey;
      for (int k = 0; k < 4; k++) begin
        trial[k] = it[j].rr[k] + rbit;
        rge[k]   = it[j].rv[k] >= trial[k];
        if (rge[k]) begin
          nxt.rv[k] = it[j].rv[k] - trial[k];
          nxt.rr[k] = (it[j].rr[k] >> 1) + rbit;
        end else begin
          nxt.rr[k] = it[j].rr[k] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it[j+1] <= nxt;
      end
    end
  end

  // Final stage: sign, offset, saturation, extremes.
  qcsl_pkg::center_t cenx_c, ceny_c;
  logic [SW-1:0]     sd_c [4];
  logic [SW-1:0]     mx01_c, mx23_c, mn01_c, mn23_c;

  assign cenx_c = qcsl_pkg::fix_center(it[QW].bx, it[QW].qx, it[QW].negx, it[QW].bigx);
  assign ceny_c = qcsl_pkg::fix_center(it[QW].by, it[QW].qy, it[QW].negy, it[QW].bigy);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sd_c[k] = it[QW].rr[k][SW-1:0];
    end
  end

  assign mx01_c = (sd_c[1] > sd_c[0]) ? sd_c[1] : sd_c[0];
  assign mx23_c = (sd_c[3] > sd_c[2]) ? sd_c[3] : sd_c[2];
  assign mn01_c = (sd_c[1] < sd_c[0]) ? sd_c[1] : sd_c[0];
  assign mn23_c = (sd_c[3] < sd_c[2]) ? sd_c[3] : sd_c[2];

  always_ff @(posedge clk) begin
    if (en) begin
      fin.side_0        <= sd_c[0];
      fin.side_1        <= sd_c[1];
      fin.side_2        <= sd_c[2];
      fin.side_3        <= sd_c[3];
      fin.largest_side  <= (mx23_c > mx01_c) ? mx23_c : mx01_c;
      fin.smallest_side <= (mn23_c < mn01_c) ? mn23_c : mn01_c;
      fin.degenerate    <= it[QW].degen;
      if (it[QW].degen) begin
        fin.center_x       <= '0;
        fin.center_y       <= '0;
        fin.center_clipped <= 1'b0;
      end else begin
        fin.center_x       <= cenx_c.val;
        fin.center_y       <= ceny_c.val;
        fin.center_clipped <= cenx_c.clip | ceny_c.clip;
      end
    end
  end

  // Skid register between the last stage and the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (result.ready) begin
        skid_v <= 1'b0;
      end
    end else if (vld[NS-1] && !result.ready) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v) begin
      skid <= fin;
    end
  end

  assign result.valid = skid_v || vld[NS-1];
  assign result.data  = skid_v ? skid : fin;

`ifndef ASSERT_OFF
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.degenerate |->
      result.data.center_x == '0 && result.data.center_y == '0 &&
      !result.data.center_clipped)
    else $error("degenerate result with nonzero center");

  a_extremes: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.smallest_side <= result.data.largest_side)
    else $error("smallest side above largest side");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(vld[NS-1] && !result.ready))
    else $error("skid register filled without a stalled result");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    skid_v |=> $stable(vld))
    else $error("pipeline moved while the skid register was full");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_v && result.ready |=> !skid_v)
    else $error("skid register kept a transaction that was taken");
`endif

endmodule

// ===== verif/qcsl_tb_checker.sv =====
module qcsl_tb_checker
  import qcsl_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input corners_t in_data,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data,
  output int     fail_count,
  output int     pending
);

  localparam int EXP_DEPTH = 64;

  result_t expected_results[EXP_DEPTH];
  int      exp_wr;
  int      exp_rd;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [CORNER_W-1:0] center_axis(
    input logic signed [63:0] base, input logic signed [63:0] tnum,
    input logic signed [63:0] delta, input logic signed [63:0] denom,
    inout logic clip);
    logic signed [127:0] prod;
    logic signed [127:0] quo;
    logic signed [127:0] v;
    prod = 128'(tnum) * 128'(delta);
    quo = prod / 128'(denom);
    v = 128'(base) + quo;
    if (v < -128'sd8388608) begin
      clip = 1'b1;
      return COORD_MIN;
    end
    if (v > 128'sd8388607) begin
      clip = 1'b1;
      return COORD_MAX;
    end
    return v[CORNER_W-1:0];
  endfunction

  function automatic result_t predict_quad(input corners_t c);
    result_t r;
    logic signed [63:0] xs[4];
    logic signed [63:0] ys[4];
    logic signed [63:0] dax, day, dbx, dby, denom, tnum, dx, dy;
    logic [63:0] len[4];
    logic clip;
    xs[0] = c.corner0_x; ys[0] = c.corner0_y;
    xs[1] = c.corner1_x; ys[1] = c.corner1_y;
    xs[2] = c.corner2_x; ys[2] = c.corner2_y;
    xs[3] = c.corner3_x; ys[3] = c.corner3_y;
    dax = xs[2] - xs[0];
    day = ys[2] - ys[0];
    dbx = xs[3] - xs[1];
    dby = ys[3] - ys[1];
    denom = dax * dby - day * dbx;
    clip = 1'b0;
    r = '0;
    r.degenerate = (denom == 0);
    if (denom != 0) begin
      tnum = (xs[1] - xs[0]) * dby - (ys[1] - ys[0]) * dbx;
      r.center_x = center_axis(xs[0], tnum, dax, denom, clip);
      r.center_y = center_axis(ys[0], tnum, day, denom, clip);
    end
    r.center_clipped = clip;
    for (int k = 0; k < 4; k++) begin
      dx = xs[(k + 1) % 4] - xs[k];
      dy = ys[(k + 1) % 4] - ys[k];
      len[k] = int_sqrt(64'(dx * dx + dy * dy));
    end
    r.side_0 = len[0][SIDE_W-1:0];
    r.side_1 = len[1][SIDE_W-1:0];
    r.side_2 = len[2][SIDE_W-1:0];
    r.side_3 = len[3][SIDE_W-1:0];
    r.largest_side = r.side_0;
    r.smallest_side = r.side_0;
    foreach (len[k]) begin
      if (len[k][SIDE_W-1:0] > r.largest_side) r.largest_side = len[k][SIDE_W-1:0];
      if (len[k][SIDE_W-1:0] < r.smallest_side) r.smallest_side = len[k][SIDE_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  assign pending = exp_wr - exp_rd;

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      exp_wr = 0;
      exp_rd = 0;
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (exp_wr - exp_rd >= EXP_DEPTH) begin
          report_mismatch("too many transactions in flight", 0, 0);
        end else begin
          expected_results[6'(exp_wr)] = predict_quad(in_data);
          exp_wr++;
        end
      end
      if (out_valid && out_ready) begin
        if (exp_wr == exp_rd) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          want = expected_results[6'(exp_rd)];
          exp_rd++;
          if (out_data.center_x !== want.center_x)
            report_mismatch("center_x", out_data.center_x, want.center_x);
          if (out_data.center_y !== want.center_y)
            report_mismatch("center_y", out_data.center_y, want.center_y);
          if (out_data.side_0 !== want.side_0)
            report_mismatch("side_0", out_data.side_0, want.side_0);
          if (out_data.side_1 !== want.side_1)
            report_mismatch("side_1", out_data.side_1, want.side_1);
          if (out_data.side_2 !== want.side_2)
            report_mismatch("side_2", out_data.side_2, want.side_2);
          if (out_data.side_3 !== want.side_3)
            report_mismatch("side_3", out_data.side_3, want.side_3);
          if (out_data.largest_side !== want.largest_side)
            report_mismatch("largest_side", out_data.largest_side, want.largest_side);
          if (out_data.smallest_side !== want.smallest_side)
            report_mismatch("smallest_side", out_data.smallest_side, want.smallest_side);
          if (out_data.degenerate !== want.degenerate)
            report_mismatch("degenerate", out_data.degenerate, want.degenerate);
          if (out_data.center_clipped !== want.center_clipped)
            report_mismatch("center_clipped", out_data.center_clipped, want.center_clipped);
        end
      end
    end
  end

endmodule

// ===== verif/quad_center_and_side_lengths_unit_tb.sv =====
module quad_center_and_side_lengths_unit_tb;
  import qcsl_pkg::*;

  localparam int RANDOM_QUADS = 1280;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIRECTED_MAX = 16;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  bit   calm_phase;
  corners_t directed_quads[DIRECTED_MAX];
  int   directed_count;

  qcsl_stream_if #(.T(corners_t)) corners ();
  qcsl_stream_if #(.T(result_t))  result ();

  quad_center_and_side_lengths_unit DUT (
    .clk(clk),
    .rst(rst),
    .corners(corners),
    .result(result)
  );

  qcsl_tb_checker checker_inst (
    .clk(clk),
    .rst(rst),
    .in_valid(corners.valid),
    .in_ready(corners.ready),
    .in_data(corners.data),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .out_data(result.data),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [CORNER_W-1:0] pick_coord(input int mode);
    case (mode)
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return CORNER_W'($urandom);
      3: return CORNER_W'($signed($urandom_range(0, 8000)) - 4000);
      default: return CORNER_W'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  function automatic corners_t make_quad(input logic signed [CORNER_W-1:0] v[8]);
    corners_t c;
    c = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
    return c;
  endfunction

  task automatic store_quad(input corners_t c);
    directed_quads[directed_count] = c;
    directed_count++;
  endtask

  task automatic add_directed();
    logic signed [CORNER_W-1:0] v[8];
    v = '{0, 0, 0, 0, 0, 0, 0, 0}; store_quad(make_quad(v));
    v = '{0, 0, 2560, 0, 2560, 2560, 0, 2560}; store_quad(make_quad(v));
    v = '{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
          COORD_MIN, COORD_MAX};
    store_quad(make_quad(v));
    v = '{COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
          COORD_MAX, COORD_MIN};
    store_quad(make_quad(v));
    // Parallel diagonals.
    v = '{0, 0, 100, 0, 300, 0, 400, 0}; store_quad(make_quad(v));
    v = '{0, 0, 5, 5, 10, 10, 15, 15}; store_quad(make_quad(v));
    // Nearly parallel diagonals push the center far out and saturate it.
    v = '{0, 0, 0, 1, COORD_MAX, 0, COORD_MAX, 2}; store_quad(make_quad(v));
    v = '{0, 0, 0, 1, COORD_MIN, 0, COORD_MIN, 2}; store_quad(make_quad(v));
    v = '{0, 0, 1, 0, 0, COORD_MAX, 2, COORD_MAX}; store_quad(make_quad(v));
    v = '{0, 0, 1, 0, 0, COORD_MIN, 2, COORD_MIN}; store_quad(make_quad(v));
    v = '{COORD_MAX, 0, COORD_MAX, 1, 0, 0, 0, 2}; store_quad(make_quad(v));
    v = '{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX,
          COORD_MAX, COORD_MIN};
    store_quad(make_quad(v));
    v = '{-1, -1, -1, -1, -1, -1, -1, -1}; store_quad(make_quad(v));
    v = '{-3, 7, 11, -5, 2, 9, -8, -4}; store_quad(make_quad(v));
  endtask

  task automatic drive_quad(input corners_t c);
    corners.valid <= 1'b1;
    corners.data  <= c;
    @(posedge clk);
    while (!corners.ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    corners.valid <= 1'b0;
    repeat ($urandom_range(1, 15)) @(posedge clk);
  endtask

  initial begin
    corners_t c;
    logic signed [CORNER_W-1:0] v[8];
    int mode;
    directed_count = 0;
    calm_phase = 1'b0;
    rst = 1'b1;
    corners.valid = 1'b0;
    corners.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    add_directed();
    for (int i = 0; i < directed_count; i++) drive_quad(directed_quads[i]);
    corners.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < RANDOM_QUADS; n++) begin
      if (n > RANDOM_QUADS - 200) calm_phase = 1'b1;
      mode = $urandom_range(0, 9);
      foreach (v[k]) v[k] = pick_coord(mode < 4 ? mode + 2 : $urandom_range(0, 4));
      c = make_quad(v);
      if (mode == 9) c.corner3_x = c.corner1_x + (c.corner2_x - c.corner0_x);
      drive_quad(c);
      if (!calm_phase && $urandom_range(0, 7) == 0) sender_gap();
    end
    corners.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    result.ready = 1'b0;
    @(negedge rst);
    forever begin
      result.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!calm_phase && $urandom_range(0, 2) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

endmodule

// ===== sim.f =====
hw/rtl/qcsl_pkg.sv
hw/rtl/qcsl_stream_if.sv
hw/rtl/quad_center_and_side_lengths_unit.sv
verif/qcsl_tb_checker.sv
verif/quad_center_and_side_lengths_unit_tb.sv
